// ===== hdl/portable_filename_validator_top_macros.svh =====
// assertion macros for the file name validator
`ifndef PORTABLE_FILENAME_VALIDATOR_TOP_MACROS_SVH
`define PORTABLE_FILENAME_VALIDATOR_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, checked out of reset
`define PFV_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, checked out of reset
`define PFV_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PFV_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define PFV_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== hdl/pfv_pkg.sv =====
// shared types and constants for the file name validator
package pfv_pkg;

    // default length limit
    localparam int MAX_NAME_LEN_DEF = 255;

    // byte codes
    localparam logic [7:0] CH_CTRL_LAST = 8'h1F;
    localparam logic [7:0] CH_DEL       = 8'h7F;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_DOT       = 8'h2E;
    localparam logic [7:0] CH_LT        = 8'h3C;
    localparam logic [7:0] CH_GT        = 8'h3E;
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_BSLASH    = 8'h5C;
    localparam logic [7:0] CH_PIPE      = 8'h7C;
    localparam logic [7:0] CH_QMARK     = 8'h3F;
    localparam logic [7:0] CH_STAR      = 8'h2A;
    localparam logic [7:0] CH_LOW_A     = 8'h61;
    localparam logic [7:0] CH_LOW_Z     = 8'h7A;
    localparam logic [7:0] CH_CASE_BIT  = 8'h20;
    localparam logic [7:0] CH_DIGIT_1   = 8'h31;
    localparam logic [7:0] CH_DIGIT_9   = 8'h39;

    // base length codes
    localparam logic [2:0] BASE_THREE = 3'd3;
    localparam logic [2:0] BASE_FULL  = 3'd4;
    localparam logic [2:0] BASE_LONG  = 3'd5;

    // reserved device names
    localparam logic [23:0] RES_CON = "CON";
    localparam logic [23:0] RES_PRN = "PRN";
    localparam logic [23:0] RES_AUX = "AUX";
    localparam logic [23:0] RES_NUL = "NUL";
    localparam logic [23:0] RES_COM = "COM";
    localparam logic [23:0] RES_LPT = "LPT";

    // classification of one name byte
    typedef struct packed {
        logic       illegal;
        logic       is_dot;
        logic       is_space;
        logic [7:0] upper;
    } t_byte_info;

endpackage

// ===== hdl/portable_filename_validator_top.sv =====
// file name validator: one byte per cycle unless a last byte is stalled, one verdict word per name
// latency: verdict shows in the cycle after the last byte is accepted
// throughput: one byte per cycle while no last byte is stalled, set by the single state update step
// an output register lets the next name start while a verdict waits
// synchronous active-low reset clears the name state and the output valid
module portable_filename_validator_top #(
    parameter int MAX_NAME_LEN = pfv_pkg::MAX_NAME_LEN_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_name_byte,
    input  logic       i_last_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_name_valid
);

    `include "portable_filename_validator_top_macros.svh"

    localparam int CW = $clog2(MAX_NAME_LEN + 2);
    localparam logic [CW-1:0] MAX_LEN = CW'(MAX_NAME_LEN);

    pfv_pkg::t_byte_info w_info;

    logic [CW-1:0] r_cnt, n_cnt;
    logic [7:0]    r_chars [4];
    logic [7:0]    n_chars [4];
    logic [2:0]    r_bcnt, n_bcnt;
    logic          r_dot, n_dot;
    logic          r_bad, n_bad;
    logic          r_out_valid;
    logic          r_name_valid;
    logic          w_accept;
    logic          w_reserved;
    logic          w_verdict;
    logic [23:0]   w_head;

    pfv_byte_check u_byte_check (
        .i_byte (i_name_byte),
        .o_info (w_info)
    );

    // handshake: only a last byte waits for a held verdict
    assign o_in_stall   = r_out_valid && i_out_stall && i_last_byte;
    assign w_accept     = i_in_valid && !o_in_stall;
    assign o_out_valid  = r_out_valid;
    assign o_name_valid = r_name_valid;

    // next name state
    always_comb begin
        n_cnt   = (r_cnt <= MAX_LEN) ? r_cnt + 1'b1 : r_cnt;
        n_chars = r_chars;
        n_bcnt  = r_bcnt;
        n_dot   = r_dot;
        n_bad   = r_bad;
        if (!r_dot && !r_bad) begin
            if (w_info.illegal) begin
                n_bad = 1'b1;
            end else if (w_info.is_dot) begin
                n_dot = 1'b1;
            end else if (r_bcnt < pfv_pkg::BASE_FULL) begin
                n_chars[r_bcnt[1:0]] = w_info.upper;
                n_bcnt = r_bcnt + 1'b1;
            end else begin
                n_bcnt = pfv_pkg::BASE_LONG;
            end
        end
    end

    // reserved device name match
    always_comb begin
        w_head = {n_chars[0], n_chars[1], n_chars[2]};
        if (n_bcnt == pfv_pkg::BASE_THREE) begin
            w_reserved = (w_head == pfv_pkg::RES_CON) || (w_head == pfv_pkg::RES_PRN) ||
                         (w_head == pfv_pkg::RES_AUX) || (w_head == pfv_pkg::RES_NUL);
        end else if (n_bcnt == pfv_pkg::BASE_FULL) begin
            w_reserved = ((w_head == pfv_pkg::RES_COM) || (w_head == pfv_pkg::RES_LPT)) &&
                         (n_chars[3] >= pfv_pkg::CH_DIGIT_1) &&
                         (n_chars[3] <= pfv_pkg::CH_DIGIT_9);
        end else begin
            w_reserved = 1'b0;
        end
    end

    // verdict on the last byte
    assign w_verdict = !n_bad && (n_cnt <= MAX_LEN) && !w_info.is_dot &&
                       !w_info.is_space && !w_reserved;

    // name state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_bcnt <= '0;
            r_dot  <= 1'b0;
            r_bad  <= 1'b0;
        end else if (w_accept) begin
            if (i_last_byte) begin
                r_cnt  <= '0;
                r_bcnt <= '0;
                r_dot  <= 1'b0;
                r_bad  <= 1'b0;
            end else begin
                r_cnt  <= n_cnt;
                r_bcnt <= n_bcnt;
                r_dot  <= n_dot;
                r_bad  <= n_bad;
            end
        end
    end

    // base characters, read only below the stored count
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_chars <= n_chars;
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept && i_last_byte) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && i_last_byte) begin
            r_name_valid <= w_verdict;
        end
    end

    // checks
    `PFV_ASSERT_NXT(a_last_clears, i_clk, i_rst_n, w_accept && i_last_byte, o_out_valid && (r_cnt == '0) && (r_bcnt == '0) && !r_dot && !r_bad, "state not cleared after last byte")
    `PFV_ASSERT_IMP(a_bcnt_range, i_clk, i_rst_n, 1'b1, r_bcnt <= pfv_pkg::BASE_LONG, "base count out of range")
    `PFV_ASSERT_IMP(a_cnt_sat, i_clk, i_rst_n, 1'b1, r_cnt <= MAX_LEN + 1'b1, "byte count past saturation")
    `PFV_ASSERT_IMP(a_dot_bad_excl, i_clk, i_rst_n, r_dot, !r_bad, "dot and bad flags both set")

endmodule

// ===== hdl/pfv_byte_check.sv =====
// per-byte classifier: illegal characters, dot, space and upper-case fold
module pfv_byte_check (
    input  logic [7:0]          i_byte,
    output pfv_pkg::t_byte_info o_info
);

    logic w_illegal;

    // forbidden byte set
    always_comb begin
        case (i_byte) inside
            [8'h00:pfv_pkg::CH_CTRL_LAST], pfv_pkg::CH_DEL, pfv_pkg::CH_LT,
            pfv_pkg::CH_GT, pfv_pkg::CH_COLON, pfv_pkg::CH_QUOTE,
            pfv_pkg::CH_SLASH, pfv_pkg::CH_BSLASH, pfv_pkg::CH_PIPE,
            pfv_pkg::CH_QMARK, pfv_pkg::CH_STAR: begin
                w_illegal = 1'b1;
            end
            default: begin
                w_illegal = 1'b0;
            end
        endcase
    end

    // classify the byte and fold lower case letters
    always_comb begin
        o_info.illegal  = w_illegal;
        o_info.is_dot   = (i_byte == pfv_pkg::CH_DOT);
        o_info.is_space = (i_byte == pfv_pkg::CH_SPACE);
        if (i_byte >= pfv_pkg::CH_LOW_A && i_byte <= pfv_pkg::CH_LOW_Z) begin
            o_info.upper = i_byte & ~pfv_pkg::CH_CASE_BIT;
        end else begin
            o_info.upper = i_byte;
        end
    end

endmodule

// ===== tb/sv/testbench.sv =====
// testbench for the file name validator: directed names, random names, scoreboard
`timescale 1ns / 100ps

module testbench;

    localparam int NAME_LIMIT = pfv_pkg::MAX_NAME_LEN_DEF;
    localparam int RAND_BYTES = 1750;
    localparam int WATCHDOG_NS = 5_000_000;
    localparam int DRAIN_CYCLES = 8;

    // verdict codes and row kinds for the directed table
    localparam logic VERDICT_OK = 1'b1;
    localparam logic VERDICT_BAD = 1'b0;
    localparam logic KNOWN = 1'b1;
    localparam logic DERIVED = 1'b0;

    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_COIN,
        SINK_HEAVY,
        SINK_PERIODIC
    } t_sink_mode;

    // one directed word; verdict only counts where known is set
    typedef struct packed {
        logic [7:0] code;
        logic       last;
        logic       known;
        logic       verdict;
    } t_dir_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    logic [7:0] i_name_byte = 8'h00;
    logic       i_last_byte = 1'b0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    logic       o_name_valid;

    // predictor state, one name in flight
    int         name_len;
    logic [7:0] base_upper [4];
    logic [2:0] base_len;
    logic       dot_hit;
    logic       bad_hit;

    logic       verdict_q [$];
    logic [7:0] name_buf [$];
    int         err_count;
    int         bytes_sent;
    int         names_sent;
    int         ok_seen;
    int         rejected_seen;
    int         burst_left;
    t_sink_mode sink_mode = SINK_OPEN;
    int         sink_left;
    int         sink_tick;

    t_dir_row dir_rows [23] = '{
        '{"a", 1'b1, KNOWN, VERDICT_OK},
        '{8'h00, 1'b1, KNOWN, VERDICT_BAD},
        '{8'hFF, 1'b1, KNOWN, VERDICT_OK},
        '{pfv_pkg::CH_DOT, 1'b1, KNOWN, VERDICT_BAD},
        '{pfv_pkg::CH_SPACE, 1'b1, KNOWN, VERDICT_BAD},
        '{"C", 1'b0, DERIVED, 1'b0},
        '{"o", 1'b0, DERIVED, 1'b0},
        '{"n", 1'b1, KNOWN, VERDICT_BAD},
        '{"l", 1'b0, DERIVED, 1'b0},
        '{"p", 1'b0, DERIVED, 1'b0},
        '{"t", 1'b0, DERIVED, 1'b0},
        '{"9", 1'b1, KNOWN, VERDICT_BAD},
        '{pfv_pkg::CH_DOT, 1'b0, DERIVED, 1'b0},
        '{pfv_pkg::CH_STAR, 1'b1, KNOWN, VERDICT_OK},
        '{pfv_pkg::CH_DEL, 1'b0, DERIVED, 1'b0},
        '{"a", 1'b1, KNOWN, VERDICT_BAD},
        '{"C", 1'b0, DERIVED, 1'b0},
        '{"O", 1'b0, DERIVED, 1'b0},
        '{"M", 1'b0, DERIVED, 1'b0},
        '{"0", 1'b1, KNOWN, VERDICT_OK},
        '{"a", 1'b0, DERIVED, 1'b0},
        '{pfv_pkg::CH_PIPE, 1'b0, DERIVED, 1'b0},
        '{"b", 1'b1, KNOWN, VERDICT_BAD}
    };

    portable_filename_validator_top #(
        .MAX_NAME_LEN(NAME_LIMIT)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_name_byte (i_name_byte),
        .i_last_byte (i_last_byte),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_name_valid(o_name_valid)
    );

    // clock
    always #5 i_clk = ~i_clk;

    // clear the predicted name state
    function automatic void clear_name();
        name_len = 0;
        base_upper = '{8'h00, 8'h00, 8'h00, 8'h00};
        base_len = 3'd0;
        dot_hit = 1'b0;
        bad_hit = 1'b0;
    endfunction

    // advance the predicted state by one byte; returns 1 when a verdict is due
    function automatic logic judge_byte(input logic [7:0] code, input logic last,
                                        output logic verdict);
        logic [23:0] stem;
        logic        reserved;
        verdict = VERDICT_BAD;
        if (name_len <= NAME_LIMIT) begin
            name_len++;
        end
        // checking stops at the first dot or the first bad byte
        if (!dot_hit && !bad_hit) begin
            if (code <= pfv_pkg::CH_CTRL_LAST ||
                    code inside {pfv_pkg::CH_DEL, pfv_pkg::CH_LT, pfv_pkg::CH_GT,
                                 pfv_pkg::CH_COLON, pfv_pkg::CH_QUOTE, pfv_pkg::CH_SLASH,
                                 pfv_pkg::CH_BSLASH, pfv_pkg::CH_PIPE, pfv_pkg::CH_QMARK,
                                 pfv_pkg::CH_STAR}) begin
                bad_hit = 1'b1;
            end else if (code == pfv_pkg::CH_DOT) begin
                dot_hit = 1'b1;
            end else if (base_len < pfv_pkg::BASE_FULL) begin
                base_upper[base_len[1:0]] =
                    (code >= pfv_pkg::CH_LOW_A && code <= pfv_pkg::CH_LOW_Z) ?
                    code - pfv_pkg::CH_CASE_BIT : code;
                base_len++;
            end else begin
                base_len = pfv_pkg::BASE_LONG;
            end
        end
        if (!last) begin
            return 1'b0;
        end
        // reserved device names, with or without a port digit
        stem = {base_upper[0], base_upper[1], base_upper[2]};
        reserved = 1'b0;
        if (base_len == pfv_pkg::BASE_THREE) begin
            reserved = stem inside {pfv_pkg::RES_CON, pfv_pkg::RES_PRN,
                                    pfv_pkg::RES_AUX, pfv_pkg::RES_NUL};
        end else if (base_len == pfv_pkg::BASE_FULL) begin
            reserved = (stem == pfv_pkg::RES_COM || stem == pfv_pkg::RES_LPT) &&
                       base_upper[3] >= pfv_pkg::CH_DIGIT_1 &&
                       base_upper[3] <= pfv_pkg::CH_DIGIT_9;
        end
        verdict = !bad_hit && name_len <= NAME_LIMIT && code != pfv_pkg::CH_DOT &&
                  code != pfv_pkg::CH_SPACE && !reserved;
        clear_name();
        return 1'b1;
    endfunction

    // offer one word and wait for the handshake, then predict
    task automatic send_byte(input logic [7:0] code, input logic last,
                             input logic known, input logic verdict);
        logic has_result;
        logic predicted;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_name_byte <= code;
        i_last_byte <= last;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        has_result = judge_byte(code, last, predicted);
        if (has_result) begin
            verdict_q.push_back(known ? verdict : predicted);
            names_sent++;
        end
        bytes_sent++;
    endtask

    // bursts of words with random gaps between them
    task automatic pace();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 30);
            if (gap > 0) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
    endtask

    // build one random name into name_buf
    task automatic build_name();
        logic [23:0] stems [6];
        logic [23:0] pick;
        logic [7:0]  ch;
        int          kind;
        int          len;
        int          roll;
        stems = '{pfv_pkg::RES_CON, pfv_pkg::RES_PRN, pfv_pkg::RES_AUX,
                  pfv_pkg::RES_NUL, pfv_pkg::RES_COM, pfv_pkg::RES_LPT};
        name_buf.delete();
        kind = $urandom_range(0, 99);
        if (kind < 40) begin
            // device-like base in mixed case, then an optional tail of some kind
            pick = stems[$urandom_range(0, 5)];
            for (int i = 0; i < 3; i++) begin
                ch = pick[23 - 8 * i -: 8];
                name_buf.push_back($urandom_range(0, 1) ? ch | pfv_pkg::CH_CASE_BIT : ch);
            end
            roll = $urandom_range(0, 9);
            if (roll < 6) begin
                name_buf.push_back(8'("0") + 8'($urandom_range(0, 9)));
            end else if (roll < 8) begin
                name_buf.push_back(8'($urandom_range(pfv_pkg::CH_LOW_A, pfv_pkg::CH_LOW_Z)));
            end
            case ($urandom_range(0, 4))
                1: begin
                    name_buf.push_back(pfv_pkg::CH_DOT);
                    repeat ($urandom_range(1, 3))
                        name_buf.push_back(8'($urandom_range(8'h21, 8'h7E)));
                end
                2: begin
                    repeat ($urandom_range(1, 3))
                        name_buf.push_back(
                            8'($urandom_range(pfv_pkg::CH_LOW_A, pfv_pkg::CH_LOW_Z)));
                end
                3: begin
                    name_buf.push_back($urandom_range(0, 1) ? pfv_pkg::CH_DOT :
                                                              pfv_pkg::CH_SPACE);
                end
                4: begin
                    name_buf.push_back(8'($urandom_range(0, 255)));
                end
                default: begin
                end
            endcase
        end else if (kind < 75) begin
            // printable name, sometimes with a dot inside
            len = $urandom_range(1, 12);
            repeat (len) name_buf.push_back(8'($urandom_range(pfv_pkg::CH_SPACE, 8'h7E)));
            if ($urandom_range(0, 9) < 3) begin
                name_buf[$urandom_range(0, len - 1)] = pfv_pkg::CH_DOT;
            end
        end else if (kind < 99) begin
            // raw bytes
            repeat ($urandom_range(1, 8)) name_buf.push_back(8'($urandom_range(0, 255)));
        end else begin
            // length right around the limit
            len = $urandom_range(NAME_LIMIT - 2, NAME_LIMIT + 3);
            repeat (len)
                name_buf.push_back(8'($urandom_range(pfv_pkg::CH_LOW_A, pfv_pkg::CH_LOW_Z)));
        end
    endtask

    // receiver stall pattern, switching style every so often
    always @(negedge i_clk) begin
        sink_tick <= sink_tick + 1;
        if (sink_left == 0) begin
            sink_mode <= t_sink_mode'($urandom_range(0, 3));
            sink_left <= $urandom_range(10, 80);
        end else begin
            sink_left <= sink_left - 1;
        end
        case (sink_mode)
            SINK_OPEN:   i_out_stall <= 1'b0;
            SINK_COIN:   i_out_stall <= 1'($urandom_range(0, 1));
            SINK_HEAVY:  i_out_stall <= ($urandom_range(0, 3) != 0);
            default:     i_out_stall <= ((sink_tick % 5) < 2);
        endcase
    end

    // verdict checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (verdict_q.size() == 0) begin
                err_count++;
                $display("%0t: verdict with none pending, expected none, got %0b",
                         $time, o_name_valid);
            end else begin
                if (o_name_valid !== verdict_q[0]) begin
                    err_count++;
                    $display("%0t: name_valid mismatch, expected %0b, got %0b",
                             $time, verdict_q[0], o_name_valid);
                end
                if (o_name_valid === VERDICT_OK) begin
                    ok_seen++;
                end else begin
                    rejected_seen++;
                end
                void'(verdict_q.pop_front());
            end
        end
    end

    // watchdog
    initial begin
        #(WATCHDOG_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

    // main sequence
    initial begin
        clear_name();
        err_count = 0;
        bytes_sent = 0;
        names_sent = 0;
        ok_seen = 0;
        rejected_seen = 0;
        burst_left = $urandom_range(1, 30);
        sink_left = 0;
        sink_tick = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed names
        foreach (dir_rows[i]) begin
            send_byte(dir_rows[i].code, dir_rows[i].last, dir_rows[i].known,
                      dir_rows[i].verdict);
            pace();
        end

        // random names
        while (bytes_sent < RAND_BYTES) begin
            build_name();
            foreach (name_buf[i]) begin
                send_byte(name_buf[i], i == name_buf.size() - 1, DERIVED, 1'b0);
                pace();
            end
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (verdict_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("streamed %0d bytes in %0d names under random gaps and stalls",
                 bytes_sent, names_sent);
        $display("verdicts seen: %0d accepted, %0d rejected, %0d errors",
                 ok_seen, rejected_seen, err_count);
        if (err_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/pfv_pkg.sv
hdl/pfv_byte_check.sv
hdl/portable_filename_validator_top.sv
tb/sv/testbench.sv
